// File: hdl/hws_pkg.sv
// Shared types, register map and payload structs for the heartbeat watchdog supervisor.
package hws_pkg;

  localparam int unsigned CntW    = 16;
  localparam int unsigned BaseW   = 8;
  localparam int unsigned RetryW  = 4;
  localparam int unsigned HoldW   = 12;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 4;

  localparam logic [CntW-1:0]   CntMax   = {CntW{1'b1}};
  localparam logic [RetryW-1:0] RetryMax = {RetryW{1'b1}};

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_CYCLE   = 2'd1,
    REG_BASE    = 2'd2,
    REG_LIMIT   = 2'd3
  } reg_idx_e;

  localparam logic [CntW-1:0]   TimeoutRst = 16'd60;
  localparam logic [CntW-1:0]   CycleRst   = 16'd28800;
  localparam logic [BaseW-1:0]  BaseRst    = 8'd15;
  localparam logic [RetryW-1:0] LimitRst   = 4'd9;

  typedef struct packed {
    logic [CntW-1:0]   timeout_seconds;
    logic [CntW-1:0]   cycle_seconds;
    logic [BaseW-1:0]  relay_base_seconds;
    logic [RetryW-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic heartbeat_level;
    logic second_tick;
  } in_t;

  typedef struct packed {
    logic              relay_on;
    logic              nav_reset;
    logic              led_pulse;
    logic [RetryW-1:0] retry_count;
    logic [HoldW-1:0]  relay_seconds_left;
  } out_t;

endpackage

// File: hdl/hws_cfg.sv
// APB-style configuration register file for the watchdog supervisor.
module hws_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hws_pkg::AddrW-1:0]   paddr,
  input  logic [hws_pkg::DataW-1:0]   pwdata,
  output logic [hws_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output hws_pkg::cfg_t               cfg_o
);
  import hws_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_TIMEOUT: cfg_d.timeout_seconds    = pwdata[CntW-1:0];
        REG_CYCLE:   cfg_d.cycle_seconds      = pwdata[CntW-1:0];
        REG_BASE:    cfg_d.relay_base_seconds = pwdata[BaseW-1:0];
        REG_LIMIT:   cfg_d.retry_limit        = pwdata[RetryW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TIMEOUT: prdata = {{(DataW-CntW){1'b0}}, cfg_q.timeout_seconds};
      REG_CYCLE:   prdata = {{(DataW-CntW){1'b0}}, cfg_q.cycle_seconds};
      REG_BASE:    prdata = {{(DataW-BaseW){1'b0}}, cfg_q.relay_base_seconds};
      REG_LIMIT:   prdata = {{(DataW-RetryW){1'b0}}, cfg_q.retry_limit};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_seconds    <= TimeoutRst;
      cfg_q.cycle_seconds      <= CycleRst;
      cfg_q.relay_base_seconds <= BaseRst;
      cfg_q.retry_limit        <= LimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/hws_core.sv
// Supervisor state and its combinational update for one sample, registered when step_i is high.
module hws_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  hws_pkg::in_t  item_i,
  input  hws_pkg::cfg_t cfg_i,
  output hws_pkg::out_t result_o
);
  import hws_pkg::*;

  logic              last_q, last_d;
  logic [CntW-1:0]   since_beat_q, since_beat_d;
  logic [CntW-1:0]   since_cycle_q, since_cycle_d;
  logic [RetryW-1:0] retries_q, retries_d;
  logic [HoldW-1:0]  relay_left_q, relay_left_d;
  logic              periodic_q, periodic_d;
  logic              nav, led;
  logic [HoldW-1:0]  esc_len;

  assign esc_len = HoldW'(cfg_i.relay_base_seconds) * HoldW'(retries_q);

  always_comb begin
    last_d        = last_q;
    since_beat_d  = since_beat_q;
    since_cycle_d = since_cycle_q;
    retries_d     = retries_q;
    relay_left_d  = relay_left_q;
    periodic_d    = periodic_q;
    nav           = 1'b0;
    led           = 1'b0;

    if (item_i.second_tick) begin
      if (since_beat_d != CntMax)  since_beat_d  = since_beat_d + 1'b1;
      if (since_cycle_d != CntMax) since_cycle_d = since_cycle_d + 1'b1;
    end

    if (relay_left_q != '0) begin
      // Hold in progress: count down, finish with a reset pulse.
      if (item_i.second_tick) begin
        relay_left_d = relay_left_q - 1'b1;
        if (relay_left_d == '0) begin
          nav          = 1'b1;
          led          = 1'b1;
          since_beat_d = '0;
          if (periodic_q) since_cycle_d = '0;
          else if (retries_d != RetryMax) retries_d = retries_d + 1'b1;
          periodic_d = 1'b0;
        end
      end
    end else begin
      if (item_i.heartbeat_level != last_q) begin
        retries_d    = '0;
        since_beat_d = '0;
        led          = 1'b1;
      end
      last_d = item_i.heartbeat_level;

      if (since_beat_d > cfg_i.timeout_seconds) begin
        if (retries_d != '0 && retries_d < cfg_i.retry_limit && esc_len != '0) begin
          // Escalate: hold the relay off first.
          relay_left_d = esc_len;
          periodic_d   = 1'b0;
        end else begin
          // Bare reset, or an escalation hold of zero length.
          nav          = 1'b1;
          led          = 1'b1;
          since_beat_d = '0;
          periodic_d   = 1'b0;
          if (retries_d != RetryMax) retries_d = retries_d + 1'b1;
        end
      end
    end

    if (relay_left_d == '0 && since_cycle_d > cfg_i.cycle_seconds) begin
      if (cfg_i.relay_base_seconds != '0) begin
        relay_left_d = HoldW'(cfg_i.relay_base_seconds);
        periodic_d   = 1'b1;
      end else begin
        nav           = 1'b1;
        led           = 1'b1;
        since_beat_d  = '0;
        since_cycle_d = '0;
        periodic_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q        <= 1'b0;
      since_beat_q  <= '0;
      since_cycle_q <= '0;
      retries_q     <= '0;
      relay_left_q  <= '0;
      periodic_q    <= 1'b0;
    end else if (step_i) begin
      last_q        <= last_d;
      since_beat_q  <= since_beat_d;
      since_cycle_q <= since_cycle_d;
      retries_q     <= retries_d;
      relay_left_q  <= relay_left_d;
      periodic_q    <= periodic_d;
    end
  end

  assign result_o.relay_on           = (relay_left_d != '0);
  assign result_o.nav_reset          = nav;
  assign result_o.led_pulse          = led;
  assign result_o.retry_count        = retries_d;
  assign result_o.relay_seconds_left = relay_left_d;

endmodule

// File: hdl/heartbeat_watchdog_supervisor_top.sv
// Top level of the heartbeat watchdog supervisor: input register, core, result register.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_stall_o  hws_pkg::in_t  (heartbeat_level, second_tick)
//   out      source     out_valid_o / out_stall_i hws_pkg::out_t (relay, reset, led, counts)
//   cfg      APB slave  psel/penable/pready      4 registers at byte address 4*i
//
// One transfer in gives one transfer out; a new sample is taken every cycle while in_stall_o is low.
// A sample passes through the input register, then the state update into the result register.
// Reset returns all counters to zero and the registers to their defaults; no clearing pass.
// A stall on the output holds the result register and, once the input register is
// also full, raises in_stall_o in the same cycle.
module heartbeat_watchdog_supervisor_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  hws_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output hws_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hws_pkg::AddrW-1:0]   paddr,
  input  logic [hws_pkg::DataW-1:0]   pwdata,
  output logic [hws_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import hws_pkg::*;

  cfg_t cfg;
  in_t  in_data_q;
  logic in_valid_q;
  out_t out_data_q, core_res;
  logic out_valid_q;
  logic advance, in_take;

  hws_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move the held sample through the core when the result slot frees up.
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & out_valid_q & out_stall_i;
  assign in_take    = in_valid_i & ~in_stall_o;

  hws_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_data_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take)      in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance)           out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_data_q  <= in_data_i;
    if (advance) out_data_q <= core_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_relay_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.relay_on == (out_data_o.relay_seconds_left != '0)))
    else $error("relay_on disagrees with remaining hold");

  a_reset_blinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.nav_reset) |-> out_data_o.led_pulse)
    else $error("reset pulse without led pulse");

  a_hold_counts_down : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_data_q.second_tick && out_valid_q && out_data_q.relay_seconds_left > 12'd1)
      |=> (out_data_o.relay_seconds_left == $past(out_data_q.relay_seconds_left) - 12'd1))
    else $error("relay hold did not count down");

endmodule
